@@ hdl/bshs_pkg.sv @@
// Shared types, constants and helper functions for the staged boiler heat supervisor.
// No dependencies; every other file takes from this package by scoped names.
`default_nettype none

package bshs_pkg;

    localparam logic [7:0] TEMP_OVER_LO = 8'd86;
    localparam logic [7:0] TEMP_HI      = 8'd100;
    localparam logic [7:0] TEMP_LO      = 8'd4;
    localparam logic [7:0] TEMP_HOT     = 8'd40;
    localparam logic [4:0] SET_OFF      = 5'd7;
    localparam logic [1:0] COUNT_TRIP   = 2'd2;
    localparam logic [1:0] COUNT_MAX    = 2'd3;
    localparam logic [2:0] STAGE_MAX    = 3'd4;
    localparam logic [2:0] SET_STEP     = 3'd5;

    localparam logic [4:0] SETPOINT_RST = 5'd13;
    localparam logic [2:0] MAX_POWER_RST = 3'd4;

    localparam logic CFG_SETPOINT  = 1'b0;
    localparam logic CFG_MAX_POWER = 1'b1;

    typedef enum logic [1:0] {
        FAULT_NONE   = 2'd0,
        FAULT_OVER   = 2'd1,
        FAULT_LOW    = 2'd2,
        FAULT_SENSOR = 2'd3
    } fault_t;

    typedef struct packed {
        logic [7:0] temp_out;
        logic [7:0] temp_in;
        logic       level_low;
        logic       heating_on;
        logic       clear_counts;
        logic       clear_fault;
    } item_t;

    typedef struct packed {
        logic [1:0] over_out;
        logic [1:0] over_in;
        logic [1:0] err_out;
        logic [1:0] err_in;
    } counts_t;

    typedef struct packed {
        counts_t counts;
        fault_t  fault;
        logic    trip;
        logic    pump_hot;
    } safety_t;

    function automatic logic [1:0] sat_inc(input logic [1:0] c);
        return (c == COUNT_MAX) ? COUNT_MAX : c + 2'd1;
    endfunction

    function automatic logic [3:0] stage_mask(input logic [2:0] stage);
        logic [3:0] m;
        case (stage)
            3'd1:    m = 4'b0001;
            3'd2:    m = 4'b0110;
            3'd3:    m = 4'b1110;
            3'd4:    m = 4'b1111;
            default: m = 4'b0000;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

@@ hdl/bshs_safety.sv @@
// Safety checks: fault counters, latched fault code and shutdown request for one word.
// Depends on bshs_pkg.
`default_nettype none

module bshs_safety (
    input  var bshs_pkg::item_t   item,
    input  var bshs_pkg::counts_t counts,
    input  var bshs_pkg::fault_t  fault,
    output var bshs_pkg::safety_t result
);

    bshs_pkg::counts_t base;
    bshs_pkg::counts_t next;
    bshs_pkg::fault_t  fault_next;
    logic              over_hit_out;
    logic              over_hit_in;
    logic              err_hit_out;
    logic              err_hit_in;
    logic              over_trip;
    logic              err_trip;

    always_comb
    begin
        base = item.clear_counts ? '0 : counts;

        over_hit_out = item.temp_out inside {[bshs_pkg::TEMP_OVER_LO + 8'd1 : bshs_pkg::TEMP_HI]};
        over_hit_in  = item.temp_in inside {[bshs_pkg::TEMP_OVER_LO + 8'd1 : bshs_pkg::TEMP_HI]};
        err_hit_out  = !(item.temp_out inside {[bshs_pkg::TEMP_LO : bshs_pkg::TEMP_HI]});
        err_hit_in   = !(item.temp_in inside {[bshs_pkg::TEMP_LO : bshs_pkg::TEMP_HI]});

        next.over_out = over_hit_out ? bshs_pkg::sat_inc(base.over_out) : base.over_out;
        next.over_in  = over_hit_in ? bshs_pkg::sat_inc(base.over_in) : base.over_in;
        next.err_out  = err_hit_out ? bshs_pkg::sat_inc(base.err_out) : base.err_out;
        next.err_in   = err_hit_in ? bshs_pkg::sat_inc(base.err_in) : base.err_in;

        over_trip = (next.over_out > bshs_pkg::COUNT_TRIP) || (next.over_in > bshs_pkg::COUNT_TRIP);
        err_trip  = (next.err_out > bshs_pkg::COUNT_TRIP) || (next.err_in > bshs_pkg::COUNT_TRIP);

        fault_next = item.clear_fault ? bshs_pkg::FAULT_NONE : fault;
        if (over_trip)
        begin
            fault_next = bshs_pkg::FAULT_OVER;
        end
        if (item.level_low)
        begin
            fault_next = bshs_pkg::FAULT_LOW;
        end
        if (err_trip)
        begin
            fault_next = bshs_pkg::FAULT_SENSOR;
        end

        result.counts   = next;
        result.fault    = fault_next;
        result.trip     = over_trip || item.level_low || err_trip;
        result.pump_hot = (item.temp_out >= bshs_pkg::TEMP_HOT)
                       || (item.temp_in >= bshs_pkg::TEMP_HOT);
    end

endmodule

`default_nettype wire

@@ hdl/bshs_heat.sv @@
// Heating stage selection from the setpoint, the average water temperature and the power cap.
// Depends on bshs_pkg.
`default_nettype none

module bshs_heat (
    input  var logic [7:0] temp_out,
    input  var logic [7:0] temp_in,
    input  var logic [4:0] setpoint_code,
    input  var logic [2:0] max_power,
    output var logic [2:0] stage
);

    logic [8:0] sum;
    logic [7:0] avg;
    logic [7:0] target;
    logic [7:0] diff;
    logic [2:0] st;
    logic [2:0] cap;

    always_comb
    begin
        sum    = {1'b0, temp_out} + {1'b0, temp_in};
        avg    = sum[8:1];
        target = 8'({3'b000, setpoint_code} * {5'b00000, bshs_pkg::SET_STEP});
        diff   = target - avg;
        st     = (diff > {5'b00000, bshs_pkg::STAGE_MAX}) ? bshs_pkg::STAGE_MAX : diff[2:0];
        cap    = (max_power > bshs_pkg::STAGE_MAX) ? bshs_pkg::STAGE_MAX : max_power;
        if ((setpoint_code == bshs_pkg::SET_OFF) || (avg >= target))
        begin
            stage = 3'd0;
        end
        else
        begin
            stage = (st > cap) ? cap : st;
        end
    end

endmodule

`default_nettype wire

@@ hdl/boiler_staged_heat_safety.sv @@
// Top level of the staged boiler heat supervisor: input register, state and result register.
// Depends on bshs_pkg, bshs_safety and bshs_heat.
//
//   Channel   Signals                                          Direction
//   input     in_valid, in_ready, temp_out .. clear_fault      in
//   result    out_valid, out_ready, heater_mask .. fault_code  out
//   config    cfg_we, cfg_index, cfg_data                      in
//
// A word is registered on acceptance and its result is registered when it advances; one
// word can be accepted every cycle unless the result stalls. The supervisor state is
// updated in the same cycle the result register loads. A stalled result holds the input
// register; in_ready drops only when both registers are full. Reset clears supervisor state.
`default_nettype none

module boiler_staged_heat_safety (
    input  var logic       clk,
    input  var logic       rst_n,
    input  var logic       in_valid,
    output var logic       in_ready,
    input  var logic [7:0] temp_out,
    input  var logic [7:0] temp_in,
    input  var logic       level_low,
    input  var logic       heating_on,
    input  var logic       clear_counts,
    input  var logic       clear_fault,
    output var logic       out_valid,
    input  var logic       out_ready,
    output var logic [3:0] heater_mask,
    output var logic [2:0] power_level,
    output var logic       pump_on,
    output var logic [1:0] fault_code,
    input  var logic       cfg_we,
    input  var logic       cfg_index,
    input  var logic [4:0] cfg_data
);

    logic              in_valid_reg;
    bshs_pkg::item_t   item_reg;
    logic              out_valid_reg;
    logic [3:0]        mask_reg;
    logic [4:0]        setpoint_reg;
    logic [2:0]        max_power_reg;
    bshs_pkg::counts_t counts_reg;
    bshs_pkg::fault_t  fault_reg;
    logic [2:0]        stage_reg;
    logic              pump_reg;

    logic              advance;
    bshs_pkg::item_t   item_next;
    bshs_pkg::safety_t safety;
    logic [2:0]        heat_stage;
    logic [2:0]        stage_next;
    logic              pump_next;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    assign item_next.temp_out     = temp_out;
    assign item_next.temp_in      = temp_in;
    assign item_next.level_low    = level_low;
    assign item_next.heating_on   = heating_on;
    assign item_next.clear_counts = clear_counts;
    assign item_next.clear_fault  = clear_fault;

    bshs_safety u_safety (
        .item   (item_reg),
        .counts (counts_reg),
        .fault  (fault_reg),
        .result (safety)
    );

    bshs_heat u_heat (
        .temp_out      (item_reg.temp_out),
        .temp_in       (item_reg.temp_in),
        .setpoint_code (setpoint_reg),
        .max_power     (max_power_reg),
        .stage         (heat_stage)
    );

    always_comb
    begin
        stage_next = stage_reg;
        pump_next  = pump_reg;
        if ((safety.fault == bshs_pkg::FAULT_NONE) && item_reg.heating_on)
        begin
            stage_next = heat_stage;
            pump_next  = 1'b1;
        end
        else if ((safety.fault == bshs_pkg::FAULT_NONE) || safety.trip)
        begin
            stage_next = 3'd0;
            pump_next  = safety.pump_hot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            setpoint_reg  <= bshs_pkg::SETPOINT_RST;
            max_power_reg <= bshs_pkg::MAX_POWER_RST;
            counts_reg    <= '0;
            fault_reg     <= bshs_pkg::FAULT_NONE;
            stage_reg     <= 3'd0;
            pump_reg      <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                counts_reg    <= safety.counts;
                fault_reg     <= safety.fault;
                stage_reg     <= stage_next;
                pump_reg      <= pump_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    bshs_pkg::CFG_SETPOINT:  setpoint_reg  <= cfg_data;
                    bshs_pkg::CFG_MAX_POWER: max_power_reg <= cfg_data[2:0];
                    default:                 setpoint_reg  <= setpoint_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
        if (advance)
        begin
            mask_reg <= bshs_pkg::stage_mask(stage_next);
        end
    end

    assign out_valid   = out_valid_reg;
    assign heater_mask = mask_reg;
    assign power_level = stage_reg;
    assign pump_on     = pump_reg;
    assign fault_code  = fault_reg;

endmodule

`default_nettype wire
